// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the Pareto front filter RTL.
// Needs no other file; the macros compile to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property checked at every clock edge outside reset.
`define PFF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pff: property check failed");
// When the antecedent holds, the consequent must hold in the next cycle.
`define PFF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pff: sequence check failed");
`else
`define PFF_ASSERT(lbl, clk, rst_n, prop)
`define PFF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/core/pff_pkg.sv -----
// Types and constants for the Pareto front filter.
// Used by pff_cell and pareto_front_filter_2d_top; depends on nothing.
package pff_pkg;

  localparam int VALUE_W = 32;
  localparam int ID_W    = 16;

  typedef struct packed {
    logic signed [VALUE_W-1:0] obj_first;
    logic signed [VALUE_W-1:0] obj_second;
    logic        [ID_W-1:0]    point_id;
    logic                      last_point;
  } pff_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] out_first;
    logic signed [VALUE_W-1:0] out_second;
    logic        [ID_W-1:0]    out_id;
    logic                      out_last;
    logic                      front_overflow;
  } pff_out_t;

  // One slot of the front.
  typedef struct packed {
    logic                      valid;
    logic signed [VALUE_W-1:0] first;
    logic signed [VALUE_W-1:0] second;
    logic        [ID_W-1:0]    ident;
  } pff_entry_t;

  // Compare results of one slot against the point under work.
  typedef struct packed {
    logic keep;       // slot sorts at or before the point
    logic dominates;  // slot dominates the point
    logic dominated;  // point dominates the slot
  } pff_stat_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_REMOVE,
    OP_INSERT,
    OP_DRAIN
  } pff_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_DRAIN
  } pff_state_t;

endpackage

// ----- rtl/core/pff_cell.sv -----
// One slot of the sorted front: compares its entry with the broadcast point
// and moves data to or from its neighbors. Depends on pff_pkg.
module pff_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  pff_pkg::pff_op_t    op,
  input  pff_pkg::pff_entry_t point,
  input  pff_pkg::pff_entry_t prev_entry,
  input  pff_pkg::pff_entry_t next_entry,
  input  logic                prev_keep,
  output pff_pkg::pff_entry_t entry,
  output pff_pkg::pff_stat_t  stat
);
  import pff_pkg::*;

  pff_entry_t entry_r;
  pff_entry_t entry_nxt;
  logic       f_lt, f_eq, s_lt, s_eq;

  always_comb begin
    f_lt = $signed(entry_r.first) < $signed(point.first);
    f_eq = entry_r.first == point.first;
    s_lt = $signed(entry_r.second) < $signed(point.second);
    s_eq = entry_r.second == point.second;

    stat.dominates = entry_r.valid & (f_lt | f_eq) & (s_lt | s_eq) & (f_lt | s_lt);
    stat.dominated = entry_r.valid & ~f_lt & ~s_lt & ~(f_eq & s_eq);
    stat.keep      = entry_r.valid & (f_lt | (f_eq & (s_lt | s_eq)));

    unique case (op)
      OP_HOLD:   entry_nxt = entry_r;
      OP_REMOVE: entry_nxt = stat.keep ? entry_r : next_entry;
      OP_INSERT: begin
        if (stat.keep) begin
          entry_nxt = entry_r;
        end else if (prev_keep) begin
          entry_nxt = point;
        end else begin
          entry_nxt = prev_entry;
        end
      end
      OP_DRAIN:  entry_nxt = next_entry;
      default:   entry_nxt = entry_r;
    endcase
  end

  // Only the valid bit is reset; the data of an empty slot is never used.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else begin
      entry_r.valid <= entry_nxt.valid;
    end
    entry_r.first  <= entry_nxt.first;
    entry_r.second <= entry_nxt.second;
    entry_r.ident  <= entry_nxt.ident;
  end

  assign entry = entry_r;

endmodule

// ----- rtl/core/pareto_front_filter_2d_top.sv -----
// Top level of the two-objective Pareto front filter (minimization).
// Depends on pff_pkg, pff_cell and assert_macros.svh.
//
// Usage: points arrive as beats on the in_ channel (valid/stall). The block
// keeps the non-dominated points in a row of FRONT_DEPTH slots, sorted by the
// first objective and then by the second. A dominated point is dropped.
// Otherwise the slots it dominates are removed and it is inserted in order.
// When the table is full, the entry with the largest key falls off the end
// and the overflow flag is set.
// Sequence: a point is taken while the block is idle, then the slot row
// removes each entry that the point dominates, one after another, and
// finally does the insert (or drop). The removal step moves one slot per
// cycle along the row. in_stall is high meanwhile.
// On a point with last_point set, the front is then streamed out on the out_
// channel, one beat per cycle from the head slot, the final beat carrying
// out_last; front_overflow is the same on every beat of the burst. The front
// and the overflow flag are cleared as the burst drains. An output register
// separates the channels: when out_stall is high the draining pauses, and a
// new point can be taken while the final beat still waits in that register.
// Reset (synchronous, active low) empties every slot and clears the flag.
`include "assert_macros.svh"

module pareto_front_filter_2d_top #(
  parameter int FRONT_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  pff_pkg::pff_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output pff_pkg::pff_out_t out_data
);
  import pff_pkg::*;

  pff_state_t state_r, state_nxt;
  pff_op_t    op;
  pff_in_t    point_r;
  pff_entry_t point_ent;
  logic       ovf_r, ovf_nxt;
  logic       out_valid_r;
  pff_out_t   out_data_r;
  logic       load_out;
  logic       drain_last;
  logic       in_take;
  logic       any_dom, any_domd;

  pff_entry_t                cell_entry [FRONT_DEPTH];
  pff_stat_t                 cell_stat  [FRONT_DEPTH];
  logic [FRONT_DEPTH-1:0]    keep_vec, dom_vec, domd_vec, valid_vec;

  localparam pff_entry_t EMPTY_ENTRY = '0;

  // The point under work is broadcast to every slot.
  assign point_ent.valid  = 1'b1;
  assign point_ent.first  = point_r.obj_first;
  assign point_ent.second = point_r.obj_second;
  assign point_ent.ident  = point_r.point_id;

  // Row of slots. The head slot treats its missing left neighbor as kept,
  // so it loads the point when it does not keep its own entry; the tail
  // slot pulls an empty entry when the row moves toward the head.
  for (genvar i = 0; i < FRONT_DEPTH; i++) begin : g_cell
    pff_entry_t prev_e, next_e;
    logic       prev_k;

    if (i == 0) begin : g_head
      assign prev_e = point_ent;
      assign prev_k = 1'b1;
    end else begin : g_body
      assign prev_e = cell_entry[i-1];
      assign prev_k = keep_vec[i-1];
    end

    if (i == FRONT_DEPTH - 1) begin : g_tail
      assign next_e = EMPTY_ENTRY;
    end else begin : g_inner
      assign next_e = cell_entry[i+1];
    end

    pff_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .op         (op),
      .point      (point_ent),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .prev_keep  (prev_k),
      .entry      (cell_entry[i]),
      .stat       (cell_stat[i])
    );

    assign keep_vec[i]  = cell_stat[i].keep;
    assign dom_vec[i]   = cell_stat[i].dominates;
    assign domd_vec[i]  = cell_stat[i].dominated;
    assign valid_vec[i] = cell_entry[i].valid;
  end

  assign any_dom    = |dom_vec;
  assign any_domd   = |domd_vec;
  assign drain_last = ~valid_vec[1];
  assign in_stall   = (state_r != ST_IDLE);
  assign in_take    = in_valid & (state_r == ST_IDLE);

  // Sequencer: take a point, remove dominated slots one per cycle, then
  // insert or drop, and drain the row on a last point.
  always_comb begin
    state_nxt = state_r;
    op        = OP_HOLD;
    ovf_nxt   = ovf_r;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (any_dom) begin
          state_nxt = point_r.last_point ? ST_DRAIN : ST_IDLE;
        end else if (any_domd) begin
          op = OP_REMOVE;
        end else begin
          op = OP_INSERT;
          // A full row pushes its largest key (maybe the point) off the end.
          if (valid_vec[FRONT_DEPTH-1]) begin
            ovf_nxt = 1'b1;
          end
          state_nxt = point_r.last_point ? ST_DRAIN : ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (!out_valid_r || !out_stall) begin
          load_out = 1'b1;
          op       = OP_DRAIN;
          if (drain_last) begin
            ovf_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovf_r   <= ovf_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      point_r <= in_data;
    end
    if (load_out) begin
      out_data_r.out_first      <= cell_entry[0].first;
      out_data_r.out_second     <= cell_entry[0].second;
      out_data_r.out_id         <= cell_entry[0].ident;
      out_data_r.out_last       <= drain_last;
      out_data_r.front_overflow <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Occupied slots always form an unbroken run from the head.
  `PFF_ASSERT(a_front_contig, clk, rst_n, ((valid_vec >> 1) & ~valid_vec) == '0)
  // Stored entries never dominate each other, so no point is both
  // dominated by one slot and dominating another.
  `PFF_ASSERT(a_no_mixed_dom, clk, rst_n, !((state_r == ST_BUSY) && any_dom && any_domd))
  // A drain always has an entry at the head to send.
  `PFF_ASSERT(a_drain_head, clk, rst_n, (state_r != ST_DRAIN) || valid_vec[0])
  // Sending the final beat returns to idle with the flag cleared.
  `PFF_ASSERT_NEXT(a_drain_end, clk, rst_n, load_out && drain_last,
                   (state_r == ST_IDLE) && !ovf_r && !valid_vec[0])

endmodule
